### rtl/deps_pkg.sv
package deps_pkg;

  typedef struct packed {
    logic [15:0]        obj;
    logic signed [31:0] vdist;
    logic [63:0]        key;
  } entry_t;

  typedef enum logic [1:0] {
    ST_SORTED   = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_STATE = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_BTF   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EMIT = 2'd2
  } state_t;

  localparam logic REG_RENDER_ORDER = 1'b0;
  localparam logic REG_DEPTH_MASK   = 1'b1;
  localparam logic CMD_ADD          = 1'b0;
  localparam logic CMD_FINISH       = 1'b1;

  function automatic logic entry_before(entry_t a, entry_t b, mode_t m);
    logic r;
    unique case (m)
      MODE_STATE: r = (a.key != b.key) ? (a.key > b.key) : (a.vdist < b.vdist);
      MODE_PIXEL: r = (a.vdist != b.vdist) ? (a.vdist < b.vdist) : (a.key > b.key);
      default:    r = (a.vdist != b.vdist) ? (a.vdist > b.vdist) : (a.key > b.key);
    endcase
    return r;
  endfunction

endpackage

### rtl/draw_entry_partition_sorter.sv
// Channel | Beat fields (lowest bit first)                          | Width
// in_     | tuser: cmd; tdata: sort_key, depth_write, distance, obj | 1, 120
// out_    | tuser: status; tdata: key, distance, object; tlast: last | 2, 112
// cfg_    | index 0 render_order, index 1 depth_write_mask          | 1, 64
// Adds stream at one beat per cycle while the sorter is idle and out_ is not stalled.
// A finish runs a selection pass over the current partition of the store per emitted entry.
// Reset clears the counts, state, flags and config registers; the store needs no clearing.
// Input is held off during a finish run and while a result waits on out_ with out_tready low.
module draw_entry_partition_sorter
  import deps_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [119:0]  in_tdata,  // sort_key, depth_write, distance, object_ref
  input  logic          in_tuser,  // cmd
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata, // out_key, out_distance, out_object
  output logic [1:0]    out_tuser, // status
  output logic          out_tlast,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [63:0]   cfg_wdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW:0] CAP_SUM = (CW + 1)'(CAPACITY);
  localparam logic [AW-1:0] TOP = AW'(CAPACITY - 1);

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  logic [1:0]  render_order_r;
  logic [63:0] depth_mask_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] first_cnt_r, first_cnt_nxt, second_cnt_r, second_cnt_nxt;
  logic          phase_r, phase_nxt;
  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] iss_r, iss_nxt, pick_r, pick_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic [AW-1:0] rd_rank_r, rd_rank_nxt;
  entry_t        best_r, best_nxt, prev_r, prev_nxt;
  logic [AW-1:0] best_rank_r, best_rank_nxt, prev_rank_r, prev_rank_nxt;
  logic          best_v_r, best_v_nxt, have_prev_r, have_prev_nxt;
  logic          out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  status_t       out_st_r, out_st_nxt;
  entry_t        out_e_r, out_e_nxt;

  logic          in_acc, out_free, wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        new_e;
  logic          dw, cmd;
  mode_t         cur_mode, cfg_mode;
  logic [CW-1:0] n_cur;
  logic          eligible, better;

  assign out_free   = !out_v_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign cmd        = in_tuser;
  assign dw         = in_tdata[64];
  assign new_e.key  = in_tdata[63:0] | (dw ? depth_mask_r : 64'd0);
  assign new_e.vdist = in_tdata[96:65];
  assign new_e.obj  = in_tdata[112:97];
  assign cfg_mode   = (render_order_r == 2'd0) ? MODE_STATE :
                      (render_order_r == 2'd1) ? MODE_PIXEL : MODE_BTF;
  assign cur_mode   = phase_r ? MODE_BTF : mode_r;
  assign n_cur      = phase_r ? second_cnt_r : first_cnt_r;
  assign rd_addr    = phase_r ? (TOP - iss_r[AW-1:0]) : iss_r[AW-1:0];

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_e_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    eligible = !have_prev_r
      || entry_before(prev_r, rd_data_r, cur_mode)
      || (!entry_before(rd_data_r, prev_r, cur_mode) && prev_rank_r < rd_rank_r);
    better = !best_v_r
      || entry_before(rd_data_r, best_r, cur_mode)
      || (!entry_before(best_r, rd_data_r, cur_mode) && rd_rank_r < best_rank_r);
  end

  always_comb begin
    state_nxt      = state_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    phase_nxt      = phase_r;
    mode_nxt       = mode_r;
    iss_nxt        = iss_r;
    pick_nxt       = pick_r;
    rd_v_nxt       = 1'b0;
    rd_rank_nxt    = rd_rank_r;
    best_nxt       = best_r;
    best_rank_nxt  = best_rank_r;
    best_v_nxt     = best_v_r;
    prev_nxt       = prev_r;
    prev_rank_nxt  = prev_rank_r;
    have_prev_nxt  = have_prev_r;
    out_v_nxt      = out_v_r && !out_tready;
    out_st_nxt     = out_st_r;
    out_e_nxt      = out_e_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = first_cnt_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd == CMD_ADD) begin
            if ({1'b0, first_cnt_r} + {1'b0, second_cnt_r} >= CAP_SUM) begin
              out_v_nxt    = 1'b1;
              out_st_nxt   = ST_OVERFLOW;
              out_e_nxt    = '0;
              out_last_nxt = 1'b0;
            end else if (cfg_mode != MODE_BTF && !dw) begin
              wr_en          = 1'b1;
              wr_addr        = TOP - second_cnt_r[AW-1:0];
              second_cnt_nxt = second_cnt_r + 1'b1;
            end else begin
              wr_en         = 1'b1;
              first_cnt_nxt = first_cnt_r + 1'b1;
            end
          end else if (first_cnt_r == '0 && second_cnt_r == '0) begin
            out_v_nxt    = 1'b1;
            out_st_nxt   = ST_EMPTY;
            out_e_nxt    = '0;
            out_last_nxt = 1'b1;
          end else begin
            mode_nxt      = cfg_mode;
            phase_nxt     = (first_cnt_r == '0);
            iss_nxt       = '0;
            pick_nxt      = '0;
            best_v_nxt    = 1'b0;
            have_prev_nxt = 1'b0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (iss_r < n_cur) begin
          iss_nxt     = iss_r + 1'b1;
          rd_v_nxt    = 1'b1;
          rd_rank_nxt = iss_r[AW-1:0];
        end
        if (rd_v_r && eligible && better) begin
          best_nxt      = rd_data_r;
          best_rank_nxt = rd_rank_r;
          best_v_nxt    = 1'b1;
        end
        if (iss_r == n_cur && !rd_v_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_v_nxt     = 1'b1;
          out_st_nxt    = ST_SORTED;
          out_e_nxt     = best_r;
          out_last_nxt  = (phase_r || second_cnt_r == '0) && (pick_r + 1'b1 == n_cur);
          prev_nxt      = best_r;
          prev_rank_nxt = best_rank_r;
          have_prev_nxt = 1'b1;
          pick_nxt      = pick_r + 1'b1;
          iss_nxt       = '0;
          best_v_nxt    = 1'b0;
          state_nxt     = S_SCAN;
          if (pick_r + 1'b1 == n_cur) begin
            if (!phase_r && second_cnt_r != '0) begin
              phase_nxt     = 1'b1;
              pick_nxt      = '0;
              have_prev_nxt = 1'b0;
            end else begin
              first_cnt_nxt  = '0;
              second_cnt_nxt = '0;
              state_nxt      = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= new_e;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      first_cnt_r    <= '0;
      second_cnt_r   <= '0;
      render_order_r <= 2'd0;
      depth_mask_r   <= 64'd0;
      out_v_r        <= 1'b0;
      rd_v_r         <= 1'b0;
      best_v_r       <= 1'b0;
      have_prev_r    <= 1'b0;
      phase_r        <= 1'b0;
      mode_r         <= MODE_STATE;
      iss_r          <= '0;
      pick_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      out_v_r      <= out_v_nxt;
      rd_v_r       <= rd_v_nxt;
      best_v_r     <= best_v_nxt;
      have_prev_r  <= have_prev_nxt;
      phase_r      <= phase_nxt;
      mode_r       <= mode_nxt;
      iss_r        <= iss_nxt;
      pick_r       <= pick_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_RENDER_ORDER) begin
          render_order_r <= cfg_wdata[1:0];
        end else begin
          depth_mask_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_rank_r   <= rd_rank_nxt;
    best_r      <= best_nxt;
    best_rank_r <= best_rank_nxt;
    prev_r      <= prev_nxt;
    prev_rank_r <= prev_rank_nxt;
    out_st_r    <= out_st_nxt;
    out_e_r     <= out_e_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

### dv/draw_entry_partition_sorter_tb.sv
module draw_entry_partition_sorter_tb;
  import deps_pkg::*;

  localparam int CAP = 64;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] key;
    logic [31:0] vdist;
    logic [15:0] obj;
    logic        last;
  } beat_t;

  typedef struct {
    logic        cmd;
    logic [63:0] key;
    logic        dw;
    logic [31:0] vdist;
    logic [15:0] obj;
    logic        has_exp;
    beat_t       exp_beat;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [63:0] cfg_wdata = '0;

  draw_entry_partition_sorter #(.CAPACITY(CAP)) dut (.*);

  always #10 clk = ~clk;

  entry_t store_q[CAP];
  int first_n, second_n;
  mode_t order_reg;
  logic [63:0] mask_reg;
  beat_t sorted_q[$];
  int errors, n_items, n_results, n_finish, n_ovf, n_empty, idle_cycles;
  int stall_left = 0;
  logic fill_phase;

  function automatic logic goes_first(entry_t a, entry_t b, mode_t m);
    if (m == MODE_STATE)
      return (a.key != b.key) ? (a.key > b.key) : (a.vdist < b.vdist);
    if (m == MODE_PIXEL)
      return (a.vdist != b.vdist) ? (a.vdist < b.vdist) : (a.key > b.key);
    return (a.vdist != b.vdist) ? (a.vdist > b.vdist) : (a.key > b.key);
  endfunction

  task automatic emit_sorted(entry_t arr[$], mode_t m, int total, ref int k);
    entry_t t;
    int j;
    for (int i = 1; i < arr.size(); i++) begin
      t = arr[i];
      j = i;
      while (j > 0 && goes_first(t, arr[j-1], m)) begin
        arr[j] = arr[j-1];
        j--;
      end
      arr[j] = t;
    end
    foreach (arr[i]) begin
      k++;
      sorted_q.push_back('{ST_SORTED, arr[i].key, arr[i].vdist, arr[i].obj, k == total});
    end
  endtask

  task automatic predict_beat(logic cmd, logic [63:0] key, logic dw, logic [31:0] vdist,
                              logic [15:0] obj);
    entry_t e;
    entry_t part[$];
    int total, k;
    if (cmd == CMD_ADD) begin
      if (first_n + second_n >= CAP) begin
        sorted_q.push_back('{ST_OVERFLOW, 64'd0, 32'd0, 16'd0, 1'b0});
        n_ovf++;
        return;
      end
      e.key = dw ? (key | mask_reg) : key;
      e.vdist = vdist;
      e.obj = obj;
      if (order_reg != MODE_BTF && !dw) begin
        store_q[CAP-1-second_n] = e;
        second_n++;
      end else begin
        store_q[first_n] = e;
        first_n++;
      end
      return;
    end
    n_finish++;
    total = first_n + second_n;
    if (total == 0) begin
      sorted_q.push_back('{ST_EMPTY, 64'd0, 32'd0, 16'd0, 1'b1});
      n_empty++;
      return;
    end
    k = 0;
    for (int i = 0; i < first_n; i++) part.push_back(store_q[i]);
    emit_sorted(part, order_reg, total, k);
    part.delete();
    for (int i = 0; i < second_n; i++) part.push_back(store_q[CAP-1-i]);
    emit_sorted(part, MODE_BTF, total, k);
    first_n = 0;
    second_n = 0;
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rand_gap();
    int g;
    g = ($urandom_range(0, 9) < 7) ? 0 : (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                                      : $urandom_range(5, 30));
    repeat (g) idle_cycle();
  endtask

  task automatic send_beat(logic cmd, logic [63:0] key, logic dw, logic [31:0] vdist,
                           logic [15:0] obj);
    @(negedge clk);
    cfg_we <= 1'b0;
    in_tuser <= cmd;
    in_tdata <= {7'd0, obj, vdist, dw, key};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beat(cmd, key, dw, vdist, obj);
    n_items++;
  endtask

  task automatic drain();
    while (sorted_q.size() != 0) idle_cycle();
    repeat (20) idle_cycle();
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_RENDER_ORDER) order_reg = (val[1:0] == 2'd3) ? MODE_BTF : mode_t'(val[1:0]);
    else mask_reg = val;
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (rst_n && (in_tvalid && in_tready || out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[63:0], out_tdata[95:64], out_tdata[111:96], out_tlast};
      n_results++;
      if (sorted_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected beat: %h", got);
      end else begin
        want = sorted_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected st=%0d key=%h dist=%h obj=%h last=%b, got st=%0d key=%h dist=%h obj=%h last=%b",
                     want.status, want.key, want.vdist, want.obj, want.last,
                     got.status, got.key, got.vdist, got.obj, got.last);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (fill_phase) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 8) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d beats outstanding.", sorted_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  row_t dir_rows[$];

  task automatic add_row(logic cmd, logic [63:0] key, logic dw, logic [31:0] vdist,
                         logic [15:0] obj, logic he, beat_t eb);
    dir_rows.push_back('{cmd, key, dw, vdist, obj, he, eb});
  endtask

  initial begin
    beat_t nb;
    int sz;
    int ph;
    logic [63:0] k;
    nb = '0;
    errors = 0; n_items = 0; n_results = 0; n_finish = 0; n_ovf = 0; n_empty = 0;
    idle_cycles = 0;
    first_n = 0; second_n = 0; order_reg = MODE_STATE; mask_reg = '0;
    fill_phase = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_row(CMD_FINISH, '0, 1'b0, '0, '0, 1'b1, '{ST_EMPTY, 64'd0, 32'd0, 16'd0, 1'b1});
    add_row(CMD_ADD, '1, 1'b1, 32'h7fffffff, 16'hffff, 1'b0, nb);
    add_row(CMD_ADD, '0, 1'b0, 32'h80000000, 16'h0000, 1'b0, nb);
    add_row(CMD_ADD, 64'h5, 1'b1, 32'h80000000, 16'h1234, 1'b0, nb);
    add_row(CMD_ADD, 64'h5, 1'b1, 32'h00010000, 16'h4321, 1'b0, nb);
    add_row(CMD_ADD, 64'h5, 1'b1, 32'h00010000, 16'h5555, 1'b0, nb);
    add_row(CMD_ADD, 64'h9, 1'b0, 32'hffffffff, 16'haaaa, 1'b0, nb);
    add_row(CMD_ADD, 64'h9, 1'b0, 32'hffffffff, 16'h0f0f, 1'b0, nb);
    add_row(CMD_FINISH, '0, 1'b0, '0, '0, 1'b0, nb);
    add_row(CMD_FINISH, '0, 1'b0, '0, '0, 1'b1, '{ST_EMPTY, 64'd0, 32'd0, 16'd0, 1'b1});
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].dw, dir_rows[i].vdist,
                dir_rows[i].obj);
      if (dir_rows[i].has_exp &&
          (sorted_q.size() == 0 || sorted_q[$] !== dir_rows[i].exp_beat)) begin
        errors++;
        $display("Directed row %0d prediction disagrees with table.", i);
      end
    end
    drain();

    write_reg(REG_DEPTH_MASK, '1);
    write_reg(REG_RENDER_ORDER, 64'd1);
    fill_phase = 1'b1;
    for (int i = 0; i < CAP + 2; i++)
      send_beat(CMD_ADD, {$urandom, $urandom}, i[0], {2'($urandom_range(0, 3)), 30'd0},
                16'($urandom));
    send_beat(CMD_FINISH, '0, 1'b0, '0, '0);
    fill_phase = 1'b0;
    drain();

    ph = 0;
    while (n_items < 420) begin
      write_reg(REG_RENDER_ORDER, 64'(ph % 4));
      write_reg(REG_DEPTH_MASK, (ph == 1) ? 64'h8000000000000000 :
                (ph == 5) ? 64'd0 : {$urandom, $urandom});
      for (int s = 0; s < 4; s++) begin
        sz = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 10) : $urandom_range(11, 30);
        for (int i = 0; i < sz; i++) begin
          rand_gap();
          k = ($urandom_range(0, 3) == 0) ? {60'd0, 4'($urandom)} : {$urandom, $urandom};
          if (s == 1 && i == sz / 2) write_reg(REG_RENDER_ORDER, 64'($urandom_range(0, 3)));
          send_beat(CMD_ADD, k, 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom,
                    16'($urandom));
        end
        rand_gap();
        send_beat(CMD_FINISH, {$urandom, $urandom}, 1'($urandom_range(0, 1)), $urandom,
                  16'($urandom));
        drain();
      end
      ph++;
    end
    drain();

    $display("Sent %0d beats over %0d finish runs; %0d result beats, %0d overflows, %0d empty.",
             n_items, n_finish, n_results, n_ovf, n_empty);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d errors, %0d beats outstanding.", errors, sorted_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
